// ===== rtl/slce_pkg.sv =====
// ----------------------------------------------------------------------------
// slce_pkg
// Types and constants shared by the stereo left-right consistency block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slce_pkg;

	localparam int FLOW_W     = 16;
	localparam int BIAS_W     = 15;
	localparam int GAIN_W     = 16;
	localparam int DISP_W     = 10;
	localparam int ERR_W      = 13;
	localparam int MAG_W      = 15;
	localparam int VMAG_W     = 2 * MAG_W;
	localparam int FRAC_W     = 4;
	localparam int WIN_AW     = 7;
	localparam int VM_AW      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int RECON_W    = 15;
	localparam int DIFF_W     = 14;
	localparam int PROD_V_W   = MAG_W + GAIN_W;
	localparam int PROD_C_W   = DIFF_W + GAIN_W;
	localparam int SUM_W      = 36;

	localparam logic [ERR_W-1:0] ERR_ONE = 13'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIAS  = 2'd0,
		REG_VGAIN = 2'd1,
		REG_CGAIN = 2'd2
	} cfg_reg_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ADDR  = 7'b0000010,
		ST_PTR   = 7'b0000100,
		ST_SAMP0 = 7'b0001000,
		ST_SAMP1 = 7'b0010000,
		ST_MUL   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic              we;
		logic [WIN_AW-1:0] addr;
		logic [DISP_W-1:0] rdisp;
		logic [DISP_W-1:0] ldisp;
		logic [VMAG_W-1:0] vmag;
	} store_wr_t;

	typedef struct packed {
		logic diff_en;
		logic prod_en;
	} arith_ctl_t;

endpackage

// ===== rtl/slce_pix_if.sv =====
// ----------------------------------------------------------------------------
// slce_pix_if
// Input channel: flow vectors of one pixel pair and the row end mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slce_pix_if import slce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FLOW_W-1:0] right_flow_x;
	logic [FLOW_W-1:0] right_flow_y;
	logic [FLOW_W-1:0] left_flow_x;
	logic [FLOW_W-1:0] left_flow_y;
	logic              row_end;

	modport source (output valid, right_flow_x, right_flow_y, left_flow_x, left_flow_y,
		row_end, input ready);
	modport sink (input valid, right_flow_x, right_flow_y, left_flow_x, left_flow_y,
		row_end, output ready);
endinterface

// ===== rtl/slce_res_if.sv =====
// ----------------------------------------------------------------------------
// slce_res_if
// Result channel: disparities and errors of one pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slce_res_if import slce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DISP_W-1:0] right_disparity;
	logic [DISP_W-1:0] left_disparity;
	logic [ERR_W-1:0]  right_error;
	logic [ERR_W-1:0]  left_error;
	logic              row_last;

	modport source (output valid, right_disparity, left_disparity, right_error, left_error,
		row_last, input ready);
	modport sink (input valid, right_disparity, left_disparity, right_error, left_error,
		row_last, output ready);
endinterface

// ===== rtl/slce_cfg_if.sv =====
// ----------------------------------------------------------------------------
// slce_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slce_cfg_if import slce_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/slce_store.sv =====
// ----------------------------------------------------------------------------
// slce_store
// Disparity windows and vertical magnitude store with registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slce_store import slce_pkg::*; (
	input  logic              clk,
	input  store_wr_t         wr,
	input  logic [WIN_AW-1:0] raddr_r,
	input  logic [WIN_AW-1:0] raddr_l,
	input  logic [VM_AW-1:0]  raddr_v,
	output logic [DISP_W-1:0] rdata_r,
	output logic [DISP_W-1:0] rdata_l,
	output logic [VMAG_W-1:0] rdata_v
);

	logic [DISP_W-1:0] rwin_mem [2**WIN_AW];
	logic [DISP_W-1:0] lwin_mem [2**WIN_AW];
	logic [VMAG_W-1:0] vmag_mem [2**VM_AW];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			rwin_mem[wr.addr] <= wr.rdisp;
			lwin_mem[wr.addr] <= wr.ldisp;
			vmag_mem[wr.addr[VM_AW-1:0]] <= wr.vmag;
		end
		rdata_r <= rwin_mem[raddr_r];
		rdata_l <= lwin_mem[raddr_l];
		rdata_v <= vmag_mem[raddr_v];
	end

endmodule

// ===== rtl/slce_arith.sv =====
// ----------------------------------------------------------------------------
// slce_arith
// Resample, mismatch, weighting and rounding for the two error lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slce_arith import slce_pkg::*; (
	input  logic                       clk,
	input  arith_ctl_t                 ctl,
	input  logic [GAIN_W-1:0]          vertical_gain,
	input  logic [GAIN_W-1:0]          consistency_gain,
	input  logic [1:0][DISP_W-1:0]     samp0,
	input  logic [1:0][DISP_W-1:0]     samp1,
	input  logic [1:0][FRAC_W-1:0]     frac,
	input  logic [1:0][DISP_W-1:0]     disp,
	input  logic [1:0][MAG_W-1:0]      vmag,
	output logic [1:0][ERR_W-1:0]      err
);

	logic [1:0][DIFF_W-1:0]   diff_s1;
	logic [1:0][PROD_V_W-1:0] pv_s2;
	logic [1:0][PROD_C_W-1:0] pc_s2;

	for (genvar i = 0; i < 2; i++) begin : g_lane
		logic [RECON_W-1:0] recon;
		logic [RECON_W-1:0] d8;
		logic [RECON_W-1:0] dif;
		logic [SUM_W-1:0]   sum;
		logic [SUM_W-1:0]   rnd;

		always_comb begin
			recon = RECON_W'((RECON_W'(16) - RECON_W'(frac[i])) * RECON_W'(samp0[i]))
				+ RECON_W'(RECON_W'(frac[i]) * RECON_W'(samp1[i]));
			d8    = RECON_W'({disp[i], 4'b0000});
			dif   = (recon > d8) ? (recon - d8) : (d8 - recon);
			sum   = SUM_W'({pv_s2[i], 4'b0000}) + SUM_W'(pc_s2[i]);
			rnd   = (sum + SUM_W'(128)) >> 8;
			err[i] = (rnd > SUM_W'(ERR_ONE)) ? ERR_ONE : rnd[ERR_W-1:0];
		end

		always_ff @(posedge clk) begin
			if (ctl.diff_en) begin
				diff_s1[i] <= dif[DIFF_W-1:0];
			end
			if (ctl.prod_en) begin
				pv_s2[i] <= PROD_V_W'(vmag[i]) * PROD_V_W'(vertical_gain);
				pc_s2[i] <= PROD_C_W'(diff_s1[i]) * PROD_C_W'(consistency_gain);
			end
		end
	end

endmodule

// ===== rtl/stereo_lr_consistency_error.sv =====
// ----------------------------------------------------------------------------
// stereo_lr_consistency_error
// Left-right disparity consistency error over a streamed row of flow vectors.
// ----------------------------------------------------------------------------
// Usage:
//   pix     takes one pixel item: right/left flow x/y (signed Q4) and row_end.
//   res     gives one item per pixel, in pixel order, MAX_DISPARITY pixels
//           behind the input; row_end (or position MAX_ROW_WIDTH-1) flushes
//           every pending pixel of the row, the last one with row_last set.
//   cfg     writes bias (index 0), vertical gain (1), consistency gain (2);
//           write only while the block is idle.
// Sequence:
//   An item is taken in the idle state; each result it releases then passes
//   through address, pointer read, two sample reads, multiply and output
//   states, and the output state waits while the receiver stalls. No new item
//   is taken until the last one is done. The single read port of each window sets this order.
// Reset clears the control and configuration registers and the row
//   position; the windows need no clearing as only current-row entries are read.
// A stalled receiver holds the output register; the block keeps taking
//   items until its next result needs that register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_lr_consistency_error import slce_pkg::*; #(
	parameter int MAX_DISPARITY = 63,
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	slce_cfg_if.sink        cfg,
	slce_pix_if.sink        pix,
	slce_res_if.source      res
);

	localparam int PW = ($clog2(MAX_ROW_WIDTH) > WIN_AW) ? $clog2(MAX_ROW_WIDTH) : WIN_AW;
	localparam int SW = PW + 2;
	localparam logic [PW-1:0]     MD_P   = PW'(MAX_DISPARITY);
	localparam logic [PW-1:0]     LAST_P = PW'(MAX_ROW_WIDTH - 1);
	localparam logic [DISP_W-1:0] MDQ    = DISP_W'(MAX_DISPARITY * 16);

	state_t              state_q;
	logic [BIAS_W-1:0]   bias_q;
	logic [GAIN_W-1:0]   vgain_q;
	logic [GAIN_W-1:0]   cgain_q;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       x_q;
	logic [PW-1:0]       xend_q;
	logic [PW-1:0]       newest_q;
	logic                flush_q;
	logic [DISP_W-1:0]   rd_q;
	logic [DISP_W-1:0]   ld_q;
	logic [VMAG_W-1:0]   vm_q;
	logic [SW-1:0]       x0r_q;
	logic [SW-1:0]       x0l_q;
	logic [FRAC_W-1:0]   fr_q;
	logic [FRAC_W-1:0]   fl_q;
	logic [DISP_W-1:0]   s0r_q;
	logic [DISP_W-1:0]   s0l_q;
	logic                out_valid_q;
	logic [DISP_W-1:0]   out_rd_q;
	logic [DISP_W-1:0]   out_ld_q;
	logic [ERR_W-1:0]    out_re_q;
	logic [ERR_W-1:0]    out_le_q;
	logic                out_last_q;

	store_wr_t            wr;
	logic [WIN_AW-1:0]    raddr_r;
	logic [WIN_AW-1:0]    raddr_l;
	logic [DISP_W-1:0]    rdata_r;
	logic [DISP_W-1:0]    rdata_l;
	logic [VMAG_W-1:0]    rdata_v;
	arith_ctl_t           actl;
	logic [1:0][DISP_W-1:0] samp1;
	logic [1:0][ERR_W-1:0]  err;

	logic                 accept;
	logic                 row_done;
	logic signed [FLOW_W:0] rsum;
	logic signed [FLOW_W:0] lsum;
	logic [SW-1:0]        x0r_c;
	logic [SW-1:0]        x0l_c;
	logic [SW-1:0]        x0r_n;
	logic [SW-1:0]        x0l_n;
	logic                 load_out;

	function automatic logic [DISP_W-1:0] clamp_disp(input logic signed [FLOW_W:0] v);
		logic [DISP_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({{(FLOW_W+1-DISP_W){1'b0}}, MDQ})) begin
			r = MDQ;
		end else begin
			r = v[DISP_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] abs_sat(input logic [FLOW_W-1:0] v);
		logic [FLOW_W-1:0] a;
		a = v[FLOW_W-1] ? (FLOW_W'(0) - v) : v;
		return a[FLOW_W-1] ? {MAG_W{1'b1}} : a[MAG_W-1:0];
	endfunction

	function automatic logic in_row(input logic [SW-1:0] idx, input logic [PW-1:0] newest);
		return !idx[SW-1] && (idx <= SW'(newest));
	endfunction

	assign accept   = pix.valid && pix.ready;
	assign row_done = pix.row_end || (pos_q == LAST_P);
	assign pix.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		rsum = $signed({pix.right_flow_x[FLOW_W-1], pix.right_flow_x})
			+ $signed({{2{bias_q[BIAS_W-1]}}, bias_q});
		lsum = $signed((FLOW_W+1)'(0))
			- $signed({pix.left_flow_x[FLOW_W-1], pix.left_flow_x})
			+ $signed({{2{bias_q[BIAS_W-1]}}, bias_q});
		wr.we    = accept;
		wr.addr  = pos_q[WIN_AW-1:0];
		wr.rdisp = clamp_disp(rsum);
		wr.ldisp = clamp_disp(lsum);
		wr.vmag  = {abs_sat(pix.left_flow_y), abs_sat(pix.right_flow_y)};
	end

	// Integer sample positions: right error reads the left map ahead, left error
	// reads the right map behind (floor of a Q4 position).
	always_comb begin
		x0r_c = SW'(x_q) + SW'(rdata_r[DISP_W-1:FRAC_W]);
		x0l_c = SW'(x_q) - SW'(rdata_l[DISP_W-1:FRAC_W]) - SW'(rdata_l[FRAC_W-1:0] != '0);
		x0r_n = x0r_q + SW'(1);
		x0l_n = x0l_q + SW'(1);
		raddr_r = x_q[WIN_AW-1:0];
		raddr_l = x_q[WIN_AW-1:0];
		unique case (state_q)
			ST_PTR: begin
				raddr_l = x0r_c[WIN_AW-1:0];
				raddr_r = x0l_c[WIN_AW-1:0];
			end
			ST_SAMP0: begin
				raddr_l = x0r_n[WIN_AW-1:0];
				raddr_r = x0l_n[WIN_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		samp1[0]     = in_row(x0r_n, newest_q) ? rdata_l : '0;
		samp1[1]     = in_row(x0l_n, newest_q) ? rdata_r : '0;
		actl.diff_en = (state_q == ST_SAMP1);
		actl.prod_en = (state_q == ST_MUL);
		load_out     = (state_q == ST_OUT) && (!out_valid_q || res.ready);
	end

	slce_store u_store (
		.clk     (clk),
		.wr      (wr),
		.raddr_r (raddr_r),
		.raddr_l (raddr_l),
		.raddr_v (x_q[VM_AW-1:0]),
		.rdata_r (rdata_r),
		.rdata_l (rdata_l),
		.rdata_v (rdata_v)
	);

	slce_arith u_arith (
		.clk              (clk),
		.ctl              (actl),
		.vertical_gain    (vgain_q),
		.consistency_gain (cgain_q),
		.samp0            ({s0l_q, s0r_q}),
		.samp1            (samp1),
		.frac             ({fl_q, fr_q}),
		.disp             ({ld_q, rd_q}),
		.vmag             ({vm_q[VMAG_W-1:MAG_W], vm_q[MAG_W-1:0]}),
		.err              (err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q  <= '0;
			vgain_q <= '0;
			cgain_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_BIAS) begin
				bias_q <= cfg.data[BIAS_W-1:0];
			end
			if (cfg.index == REG_VGAIN) begin
				vgain_q <= cfg.data;
			end
			if (cfg.index == REG_CGAIN) begin
				cgain_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			x_q         <= '0;
			xend_q      <= '0;
			newest_q    <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new item, else drop the one the receiver took.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						newest_q <= pos_q;
						if (row_done) begin
							x_q     <= (pos_q >= MD_P) ? (pos_q - MD_P) : '0;
							xend_q  <= pos_q;
							flush_q <= 1'b1;
							pos_q   <= '0;
							state_q <= ST_ADDR;
						end else begin
							x_q     <= pos_q - MD_P;
							xend_q  <= pos_q - MD_P;
							flush_q <= 1'b0;
							pos_q   <= pos_q + PW'(1);
							if (pos_q >= MD_P) begin
								state_q <= ST_ADDR;
							end
						end
					end
				end
				ST_ADDR:  state_q <= ST_PTR;
				ST_PTR:   state_q <= ST_SAMP0;
				ST_SAMP0: state_q <= ST_SAMP1;
				ST_SAMP1: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_OUT;
				ST_OUT: begin
					if (load_out) begin
						if (x_q == xend_q) begin
							state_q <= ST_IDLE;
						end else begin
							x_q     <= x_q + PW'(1);
							state_q <= ST_ADDR;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PTR) begin
			rd_q  <= rdata_r;
			ld_q  <= rdata_l;
			vm_q  <= rdata_v;
			x0r_q <= x0r_c;
			x0l_q <= x0l_c;
			fr_q  <= rdata_r[FRAC_W-1:0];
			fl_q  <= FRAC_W'(0) - rdata_l[FRAC_W-1:0];
		end
		if (state_q == ST_SAMP0) begin
			s0r_q <= in_row(x0r_q, newest_q) ? rdata_l : '0;
			s0l_q <= in_row(x0l_q, newest_q) ? rdata_r : '0;
		end
		if (load_out) begin
			out_rd_q   <= rd_q;
			out_ld_q   <= ld_q;
			out_re_q   <= err[0];
			out_le_q   <= err[1];
			out_last_q <= flush_q && (x_q == xend_q);
		end
	end

	assign res.valid           = out_valid_q;
	assign res.right_disparity = out_rd_q;
	assign res.left_disparity  = out_ld_q;
	assign res.right_error     = out_re_q;
	assign res.left_error      = out_le_q;
	assign res.row_last        = out_last_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (x_q <= xend_q && xend_q <= newest_q))
		else $error("emit span out of order");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PTR) |-> $past(state_q == ST_ADDR))
		else $error("pointer read without address cycle");

	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pix.row_end) |=> (pos_q == '0 && flush_q))
		else $error("row end did not restart position");
`endif

endmodule

// ===== bench/slce_lrc_checker.sv =====
// ----------------------------------------------------------------------------
// slce_lrc_checker
// Watches the register, pixel and result channels of the consistency block,
// keeps its own copy of the disparity windows and predicts every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slce_lrc_checker import slce_pkg::*; #(
	parameter int MAX_DISPARITY = 63,
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic clk,
	input  logic arst_n,
	slce_cfg_if  cfg,
	slce_pix_if  pix,
	slce_res_if  res,
	output int   fail_count,
	output int   pending,
	output int   checked
);

	typedef struct {
		logic [DISP_W-1:0] rdisp;
		logic [DISP_W-1:0] ldisp;
		logic [ERR_W-1:0]  rerr;
		logic [ERR_W-1:0]  lerr;
		logic              last;
	} pixel_result_t;

	localparam int DISP_MAX = MAX_DISPARITY * 16;

	pixel_result_t     expected_q[$];
	int                bias;
	int unsigned       vgain;
	int unsigned       cgain;
	logic [DISP_W-1:0] rwin [128];
	logic [DISP_W-1:0] lwin [128];
	logic [VMAG_W-1:0] vmag_mem [64];
	int                row_pos;

	assign pending = expected_q.size();

	function automatic int clamp_disp(int v);
		if (v < 0)
			return 0;
		if (v > DISP_MAX)
			return DISP_MAX;
		return v;
	endfunction

	function automatic int mag15(logic [FLOW_W-1:0] v);
		int s;
		s = $signed(v);
		if (s < 0)
			s = -s;
		return (s > 32767) ? 32767 : s;
	endfunction

	// Linear read at Q4 position u of one window; positions off the row read zero.
	function automatic longint interp(bit from_left, int u, int newest);
		int     x0;
		int     f;
		longint a;
		longint b;
		x0 = u >>> 4;
		f  = u & 15;
		a  = 0;
		b  = 0;
		if (x0 >= 0 && x0 <= newest)
			a = from_left ? lwin[x0 & 127] : rwin[x0 & 127];
		if (x0 + 1 >= 0 && x0 + 1 <= newest)
			b = from_left ? lwin[(x0 + 1) & 127] : rwin[(x0 + 1) & 127];
		return (16 - f) * a + f * b;
	endfunction

	function automatic logic [ERR_W-1:0] error_q12(longint vm, longint recon, longint disp);
		longint d8;
		longint diff;
		longint s;
		d8   = disp << 4;
		diff = (recon > d8) ? recon - d8 : d8 - recon;
		s    = ((vm * vgain) << 4) + diff * cgain;
		s    = (s + 128) >>> 8;
		return (s > 4096) ? ERR_ONE : ERR_W'(s);
	endfunction

	function automatic pixel_result_t result_at(int x, int newest, bit last);
		pixel_result_t r;
		int            rd;
		int            ld;
		rd      = rwin[x & 127];
		ld      = lwin[x & 127];
		r.rdisp = DISP_W'(rd);
		r.ldisp = DISP_W'(ld);
		r.rerr  = error_q12(vmag_mem[x & 63][MAG_W-1:0], interp(1'b1, x * 16 + rd, newest),
			rd);
		r.lerr  = error_q12(vmag_mem[x & 63][VMAG_W-1:MAG_W],
			interp(1'b0, x * 16 - ld, newest), ld);
		r.last  = last;
		return r;
	endfunction

	task automatic take_pixel();
		int p;
		int x;
		p = row_pos % MAX_ROW_WIDTH;
		rwin[p & 127]    = DISP_W'(clamp_disp($signed(pix.right_flow_x) + bias));
		lwin[p & 127]    = DISP_W'(clamp_disp(-$signed(pix.left_flow_x) + bias));
		vmag_mem[p & 63] = {MAG_W'(mag15(pix.left_flow_y)), MAG_W'(mag15(pix.right_flow_y))};
		if (pix.row_end || p == MAX_ROW_WIDTH - 1) begin
			x = (p > MAX_DISPARITY) ? p - MAX_DISPARITY : 0;
			for (; x <= p; x++)
				expected_q.insert(expected_q.size(), result_at(x, p, x == p));
			row_pos = 0;
		end else begin
			if (p >= MAX_DISPARITY)
				expected_q.insert(expected_q.size(),
					result_at(p - MAX_DISPARITY, p, 1'b0));
			row_pos = p + 1;
		end
	endtask

	task automatic compare_field(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$display("%t mismatch %s: expected %0d actual %0d", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t e;
		if (!arst_n) begin
			expected_q.delete();
			bias       = 0;
			vgain      = 0;
			cgain      = 0;
			row_pos    = 0;
			fail_count = 0;
			checked    = 0;
			for (int i = 0; i < 128; i++) begin
				rwin[i] = '0;
				lwin[i] = '0;
			end
			for (int i = 0; i < 64; i++)
				vmag_mem[i] = '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_BIAS:  bias = $signed(cfg.data[BIAS_W-1:0]);
					REG_VGAIN: vgain = cfg.data;
					REG_CGAIN: cgain = cfg.data;
					default: ;
				endcase
			end
			if (pix.valid && pix.ready)
				take_pixel();
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$display("%t unexpected result: expected none actual rd=%0d ld=%0d",
						$time, res.right_disparity, res.left_disparity);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					compare_field("right_disparity", e.rdisp, res.right_disparity);
					compare_field("left_disparity", e.ldisp, res.left_disparity);
					compare_field("right_error", e.rerr, res.right_error);
					compare_field("left_error", e.lerr, res.left_error);
					compare_field("row_last", e.last, res.row_last);
				end
				checked++;
			end
		end
	end

endmodule

// ===== bench/stereo_lr_consistency_error_tb.sv =====
// ----------------------------------------------------------------------------
// stereo_lr_consistency_error_tb
// Drives rows of flow vectors and register settings into the consistency
// block with random gaps and stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_lr_consistency_error_tb;
	import slce_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   checked;
	int   sent = 0;
	int   settings = 0;
	bit   no_gap = 1'b0;
	bit   no_stall = 1'b0;

	slce_cfg_if cfg_ch ();
	slce_pix_if pix_ch ();
	slce_res_if res_ch ();

	stereo_lr_consistency_error DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.pix(pix_ch),
		.res(res_ch)
	);

	slce_lrc_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.pix(pix_ch),
		.res(res_ch),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	always #2 clk = ~clk;

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Result side: stall a random count before each item.
	initial begin
		int n;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = no_stall ? 0 : $urandom_range(0, 8);
			if (n > 0) begin
				res_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait for the block to drain, then load a full register setting.
	task automatic set_regs(int bias, int vg, int cg);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		write_reg(REG_BIAS, {1'($urandom), BIAS_W'(bias)});
		write_reg(REG_VGAIN, CFG_DATA_W'(vg));
		write_reg(REG_CGAIN, CFG_DATA_W'(cg));
		settings++;
	endtask

	task automatic send_pixel(int rfx, int rfy, int lfx, int lfy, bit last);
		int n;
		n = no_gap ? 0 : $urandom_range(0, 8);
		if (n > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		pix_ch.right_flow_x <= FLOW_W'(rfx);
		pix_ch.right_flow_y <= FLOW_W'(rfy);
		pix_ch.left_flow_x  <= FLOW_W'(lfx);
		pix_ch.left_flow_y  <= FLOW_W'(lfy);
		pix_ch.row_end      <= last;
		pix_ch.valid        <= 1'b1;
		do @(posedge clk); while (!pix_ch.ready);
		sent++;
	endtask

	task automatic pause_input();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int rand_flow_x();
		case ($urandom_range(0, 9))
			0:       return $signed(16'($urandom));
			1:       return $urandom_range(0, 1) ? 32767 : -32768;
			default: return int'($urandom_range(0, 2400)) - 1200;
		endcase
	endfunction

	function automatic int rand_flow_y();
		case ($urandom_range(0, 9))
			0:       return $signed(16'($urandom));
			1:       return -32768;
			default: return int'($urandom_range(0, 200)) - 100;
		endcase
	endfunction

	task automatic random_rows(int budget, int max_len);
		int len;
		while (budget > 0) begin
			len = $urandom_range(0, 5) == 0 ? $urandom_range(1, 10) : $urandom_range(1, max_len);
			if (len > budget)
				len = budget;
			for (int i = 0; i < len; i++)
				send_pixel(rand_flow_x(), rand_flow_y(), rand_flow_x(), rand_flow_y(),
					i == len - 1);
			budget -= len;
		end
		pause_input();
	endtask

	initial begin
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_BIAS;
		cfg_ch.data         = '0;
		pix_ch.valid        = 1'b0;
		pix_ch.right_flow_x = '0;
		pix_ch.right_flow_y = '0;
		pix_ch.left_flow_x  = '0;
		pix_ch.left_flow_y  = '0;
		pix_ch.row_end      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-pixel row at reset settings, then extremes in a one-pixel row and a short row.
		send_pixel(0, 0, 0, 0, 1'b1);
		pause_input();
		set_regs(8, 700, 900);
		send_pixel(32767, -32768, -32768, 32767, 1'b1);
		send_pixel(-32768, 32767, 32767, -32768, 1'b0);
		send_pixel(1008, -32768, -1008, -1, 1'b0);
		send_pixel(16, 1, -16, 16, 1'b0);
		send_pixel(-1, 0, 1, 0, 1'b0);
		for (int i = 0; i < 14; i++)
			send_pixel(i * 72 - 8, i, -(i * 72) + 8, -i, 1'b0);
		send_pixel(24, 5, -24, -5, 1'b1);
		pause_input();

		set_regs(0, 2000, 300);
		random_rows(90, 140);

		set_regs(16383, 65535, 65535);
		random_rows(50, 100);
		set_regs(-16384, 0, 0);
		random_rows(50, 100);
		set_regs(int'($urandom_range(0, 800)) - 200, $urandom_range(0, 65535),
			$urandom_range(0, 2000));
		no_gap = 1'b1;
		random_rows(120, 150);
		no_gap   = 1'b0;
		no_stall = 1'b1;
		set_regs($urandom_range(0, 32767), $urandom_range(0, 65535), $urandom_range(0, 65535));
		random_rows(90, 140);
		no_stall = 1'b0;

		wait (pending == 0);
		repeat (60) @(posedge clk);
		$display("Sent %0d pixels under %0d register settings; %0d results checked.",
			sent, settings, checked);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
